// ===== design/drive_power_sequencer_unit_defines.svh =====
// Assertion helpers used by the sequencer RTL.
// Each expects clk_i and rst_ni in scope.
`ifndef DRIVE_POWER_SEQUENCER_UNIT_DEFINES_SVH
`define DRIVE_POWER_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dps_pkg.sv =====
package dps_pkg;

  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_OFF    = 3'd1,
    MODE_ACTIVE = 3'd2,
    MODE_DISCH  = 3'd3,
    MODE_ESTOP  = 3'd4,
    MODE_FAULT  = 3'd5
  } mode_e;

  // register indexes on the config channel
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_CELL_TEMP_LIMIT  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CELL_VOLT_LIMIT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BOARD_TEMP_LIMIT = 2'd2;

  localparam logic [7:0]  CELL_TEMP_LIMIT_RST  = 8'd60;
  localparam logic [15:0] CELL_VOLT_LIMIT_RST  = 16'd3000;
  localparam logic [15:0] BOARD_TEMP_LIMIT_RST = 16'd70;

  localparam logic [28:0] ID_CELLS = 29'h2D0A;
  localparam logic [28:0] ID_BOARD = 29'h2C0A;

  typedef struct packed {
    logic [7:0]  cell_temp;
    logic [15:0] cell_volt;
    logic [15:0] board_temp;
  } limits_t;

  typedef struct packed {
    logic        func;
    logic        estop_on;
    logic        ignition_on;
    logic [28:0] frame_id;
    logic [7:0]  payload_byte0;
    logic [7:0]  payload_byte1;
    logic [7:0]  payload_byte6;
  } item_t;

  typedef struct packed {
    logic green;
    logic yellow;
    logic red;
    logic fault;
    logic severe;
    logic lv;
  } levels_t;

  typedef struct packed {
    levels_t    levels;
    logic       send_enable_frame;
    logic       pulse_controller_on;
    logic       pulse_controller_off;
    logic [2:0] mode_now;
  } result_t;

endpackage

// ===== design/dps_ifs.sv =====
interface dps_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic        estop_on;
  logic        ignition_on;
  logic [28:0] frame_id;
  logic [7:0]  payload_byte0;
  logic [7:0]  payload_byte1;
  logic [7:0]  payload_byte6;

  modport source (output valid, func, estop_on, ignition_on, frame_id,
                  payload_byte0, payload_byte1, payload_byte6, input ready);
  modport sink (input valid, func, estop_on, ignition_on, frame_id,
                payload_byte0, payload_byte1, payload_byte6, output ready);
endinterface

interface dps_out_if;
  logic       valid;
  logic       ready;
  logic       green_lamp;
  logic       yellow_lamp;
  logic       red_lamp;
  logic       fault_lamp;
  logic       severe_fault_lamp;
  logic       low_volt_enable;
  logic       send_enable_frame;
  logic       pulse_controller_on;
  logic       pulse_controller_off;
  logic [2:0] mode_now;

  modport source (output valid, green_lamp, yellow_lamp, red_lamp, fault_lamp,
                  severe_fault_lamp, low_volt_enable, send_enable_frame,
                  pulse_controller_on, pulse_controller_off, mode_now,
                  input ready);
  modport sink (input valid, green_lamp, yellow_lamp, red_lamp, fault_lamp,
                severe_fault_lamp, low_volt_enable, send_enable_frame,
                pulse_controller_on, pulse_controller_off, mode_now,
                output ready);
endinterface

interface dps_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [dps_pkg::CfgIdxW-1:0]  index;
  logic [15:0]                  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/dps_sequencer.sv =====
`include "drive_power_sequencer_unit_defines.svh"

module dps_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  dps_pkg::item_t   item_i,
  input  dps_pkg::limits_t limits_i,
  output dps_pkg::result_t result_o
);
  import dps_pkg::*;

  mode_e       mode_q, mode_d;
  logic        entered_q, entered_d;
  logic [7:0]  hot_q, hot_d;
  logic [15:0] volt_q, volt_d;
  logic [15:0] board_q, board_d;
  levels_t     lvl_q, lvl_d;
  logic        send_frame, pulse_on, pulse_off;
  logic        warn;
  logic        estop, ign;

  assign estop = item_i.estop_on;
  assign ign   = item_i.ignition_on;
  assign warn  = (hot_q > limits_i.cell_temp) || (volt_q < limits_i.cell_volt) ||
                 (board_q > limits_i.board_temp);

  always_comb begin
    mode_d     = mode_q;
    entered_d  = entered_q;
    hot_d      = hot_q;
    volt_d     = volt_q;
    board_d    = board_q;
    lvl_d      = lvl_q;
    send_frame = 1'b0;
    pulse_on   = 1'b0;
    pulse_off  = 1'b0;
    if (item_i.func) begin
      if (item_i.frame_id == ID_CELLS) begin
        hot_d  = item_i.payload_byte6;
        volt_d = {item_i.payload_byte0, item_i.payload_byte1};
      end else if (item_i.frame_id == ID_BOARD) begin
        board_d = {item_i.payload_byte0, item_i.payload_byte1};
      end
    end else begin
      if (warn) lvl_d.red = 1'b1;
      case (mode_q)
        MODE_START: begin
          // entry flag is left set so the next state runs its entry actions
          if (entered_q) begin
            mode_d = estop ? MODE_ESTOP : MODE_OFF;
          end else begin
            mode_d    = MODE_FAULT;
            entered_d = 1'b1;
          end
        end
        MODE_OFF: begin
          if (entered_q) begin
            lvl_d.yellow = 1'b1;
            entered_d    = 1'b0;
          end
          if (estop || ign) begin
            mode_d       = estop ? MODE_ESTOP : MODE_ACTIVE;
            lvl_d.yellow = 1'b0;
            entered_d    = 1'b1;
          end
        end
        MODE_ACTIVE: begin
          if (entered_q) begin
            lvl_d.green = 1'b1;
            lvl_d.lv    = 1'b1;
            send_frame  = 1'b1;
            pulse_on    = 1'b1;
            entered_d   = 1'b0;
          end
          if (estop || !ign) begin
            mode_d      = MODE_DISCH;
            lvl_d.lv    = 1'b0;
            lvl_d.green = 1'b0;
            entered_d   = 1'b1;
          end
        end
        MODE_DISCH: begin
          if (entered_q) begin
            pulse_off = 1'b1;
            mode_d    = estop ? MODE_ESTOP : MODE_OFF;
          end else begin
            mode_d    = MODE_FAULT;
            entered_d = 1'b1;
          end
        end
        MODE_ESTOP: begin
          if (entered_q) begin
            lvl_d.red = 1'b1;
            entered_d = 1'b0;
          end
          if (!estop && !ign) begin
            mode_d    = MODE_OFF;
            lvl_d.red = 1'b0;
            entered_d = 1'b1;
          end
        end
        MODE_FAULT: begin
          if (entered_q) begin
            lvl_d.red    = 1'b1;
            lvl_d.fault  = 1'b1;
            lvl_d.severe = 1'b1;
            entered_d    = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_START;
      entered_q <= 1'b1;
      hot_q     <= 8'h00;
      volt_q    <= 16'hFFFF;
      board_q   <= 16'h0000;
      lvl_q     <= '0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      entered_q <= entered_d;
      hot_q     <= hot_d;
      volt_q    <= volt_d;
      board_q   <= board_d;
      lvl_q     <= lvl_d;
    end
  end

  assign result_o.levels               = lvl_d;
  assign result_o.send_enable_frame    = send_frame;
  assign result_o.pulse_controller_on  = pulse_on;
  assign result_o.pulse_controller_off = pulse_off;
  assign result_o.mode_now             = mode_d;

  `DPS_ASSERT_NXT(a_fault_sticky, mode_q == MODE_FAULT, mode_q == MODE_FAULT,
                  "fault state was left")
  `DPS_ASSERT_NXT(a_frame_keeps_mode, fire_i && item_i.func, $stable(mode_q),
                  "telemetry item changed mode")
  `DPS_ASSERT_IMP(a_green_tracks_lv, 1'b1, lvl_q.green == lvl_q.lv,
                  "green lamp and low-voltage enable disagree")
  `DPS_ASSERT_IMP(a_fault_lamps, lvl_q.fault, lvl_q.severe && lvl_q.red,
                  "fault lamp without severe and red lamps")

endmodule

// ===== design/drive_power_sequencer_unit.sv =====
// Drive power sequencer.
// Channels: in_i takes items (func 0 = step with estop/ignition levels,
// func 1 = battery telemetry frame); out_o gives one result per item with
// lamp levels, low-voltage enable, one-shot requests and the current mode.
// cfg_i writes the three telemetry limits (index 0 cell temp, 1 cell volt,
// 2 board temp); it is always ready and unknown indexes are dropped.
// Items pass through two registers: the input register, then the result register.
// Throughput: one item per cycle while out_o is not stalled; the sequencer
// state is updated as an item moves from the input register to the result register.
// The input register and the result register each hold one item, so the
// block keeps taking items while one result waits; when out_o stalls with
// both registers full, in_i.ready drops until the result is taken.
// Reset (rst_ni low, async): mode start with entry pending, telemetry
// cleared (weakest cell voltage all ones), all lamps and enable off,
// limits back to their defaults, both pipeline registers empty.
module drive_power_sequencer_unit (
  input  logic clk_i,
  input  logic rst_ni,
  dps_cfg_if.sink   cfg_i,
  dps_in_if.sink    in_i,
  dps_out_if.source out_o
);
  import dps_pkg::*;

  limits_t limits_q;
  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t out_q;
  result_t result;
  logic    advance;
  logic    in_take;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.cell_temp  <= CELL_TEMP_LIMIT_RST;
      limits_q.cell_volt  <= CELL_VOLT_LIMIT_RST;
      limits_q.board_temp <= BOARD_TEMP_LIMIT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_CELL_TEMP_LIMIT)  limits_q.cell_temp  <= cfg_i.data[7:0];
      if (cfg_i.index == CFG_CELL_VOLT_LIMIT)  limits_q.cell_volt  <= cfg_i.data;
      if (cfg_i.index == CFG_BOARD_TEMP_LIMIT) limits_q.board_temp <= cfg_i.data;
    end
  end

  // pipeline control
  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_take || (s1_valid_q && !advance);
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.func          <= in_i.func;
      s1_item_q.estop_on      <= in_i.estop_on;
      s1_item_q.ignition_on   <= in_i.ignition_on;
      s1_item_q.frame_id      <= in_i.frame_id;
      s1_item_q.payload_byte0 <= in_i.payload_byte0;
      s1_item_q.payload_byte1 <= in_i.payload_byte1;
      s1_item_q.payload_byte6 <= in_i.payload_byte6;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  dps_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (s1_item_q),
    .limits_i (limits_q),
    .result_o (result)
  );

  assign out_o.valid                = out_valid_q;
  assign out_o.green_lamp           = out_q.levels.green;
  assign out_o.yellow_lamp          = out_q.levels.yellow;
  assign out_o.red_lamp             = out_q.levels.red;
  assign out_o.fault_lamp           = out_q.levels.fault;
  assign out_o.severe_fault_lamp    = out_q.levels.severe;
  assign out_o.low_volt_enable      = out_q.levels.lv;
  assign out_o.send_enable_frame    = out_q.send_enable_frame;
  assign out_o.pulse_controller_on  = out_q.pulse_controller_on;
  assign out_o.pulse_controller_off = out_q.pulse_controller_off;
  assign out_o.mode_now             = out_q.mode_now;

endmodule

// ===== sim/power_seq_checker.sv =====
module power_seq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  dps_cfg_if          cfg_mon,
  dps_in_if           in_mon,
  dps_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dps_pkg::*;

  limits_t     limits;
  mode_e       mode;
  logic        entering;
  logic [7:0]  hottest_cell;
  logic [15:0] weakest_cell_volt;
  logic [15:0] board_temp;
  levels_t     levels;
  result_t     predicted_results[$];

  // Sequencer state update for one item; returns the result it should produce.
  function automatic result_t advance_sequencer(item_t it);
    result_t r;
    r = '0;
    if (it.func) begin
      if (it.frame_id == ID_CELLS) begin
        hottest_cell      = it.payload_byte6;
        weakest_cell_volt = {it.payload_byte0, it.payload_byte1};
      end else if (it.frame_id == ID_BOARD) begin
        board_temp = {it.payload_byte0, it.payload_byte1};
      end
    end else begin
      // battery warning is sticky until something clears the red lamp
      if (hottest_cell > limits.cell_temp || weakest_cell_volt < limits.cell_volt ||
          board_temp > limits.board_temp) begin
        levels.red = 1'b1;
      end
      case (mode)
        MODE_START: begin
          if (entering) begin
            mode = it.estop_on ? MODE_ESTOP : MODE_OFF;
          end else begin
            mode     = MODE_FAULT;
            entering = 1'b1;
          end
        end
        MODE_OFF: begin
          if (entering) begin
            levels.yellow = 1'b1;
            entering      = 1'b0;
          end
          if (it.estop_on || it.ignition_on) begin
            mode          = it.estop_on ? MODE_ESTOP : MODE_ACTIVE;
            levels.yellow = 1'b0;
            entering      = 1'b1;
          end
        end
        MODE_ACTIVE: begin
          if (entering) begin
            levels.green          = 1'b1;
            levels.lv             = 1'b1;
            r.send_enable_frame   = 1'b1;
            r.pulse_controller_on = 1'b1;
            entering              = 1'b0;
          end
          if (it.estop_on || !it.ignition_on) begin
            mode         = MODE_DISCH;
            levels.lv    = 1'b0;
            levels.green = 1'b0;
            entering     = 1'b1;
          end
        end
        MODE_DISCH: begin
          if (entering) begin
            r.pulse_controller_off = 1'b1;
            mode = it.estop_on ? MODE_ESTOP : MODE_OFF;
          end else begin
            mode     = MODE_FAULT;
            entering = 1'b1;
          end
        end
        MODE_ESTOP: begin
          if (entering) begin
            levels.red = 1'b1;
            entering   = 1'b0;
          end
          if (!it.estop_on && !it.ignition_on) begin
            mode       = MODE_OFF;
            levels.red = 1'b0;
            entering   = 1'b1;
          end
        end
        MODE_FAULT: begin
          if (entering) begin
            levels.red    = 1'b1;
            levels.fault  = 1'b1;
            levels.severe = 1'b1;
            entering      = 1'b0;
          end
        end
        default: ;
      endcase
    end
    r.levels   = levels;
    r.mode_now = mode;
    return r;
  endfunction

  function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t seen;
    result_t want;
    item_t   it;
    if (!rst_ni) begin
      limits.cell_temp  = CELL_TEMP_LIMIT_RST;
      limits.cell_volt  = CELL_VOLT_LIMIT_RST;
      limits.board_temp = BOARD_TEMP_LIMIT_RST;
      mode              = MODE_START;
      entering          = 1'b1;
      hottest_cell      = '0;
      weakest_cell_volt = '1;
      board_temp        = '0;
      levels            = '0;
      predicted_results.delete();
      pending_o         = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_CELL_TEMP_LIMIT:  limits.cell_temp  = cfg_mon.data[7:0];
          CFG_CELL_VOLT_LIMIT:  limits.cell_volt  = cfg_mon.data;
          CFG_BOARD_TEMP_LIMIT: limits.board_temp = cfg_mon.data;
          default: ;
        endcase
      end
      // a result never leaves at the edge its item is taken, so check before predicting
      if (out_mon.valid && out_mon.ready) begin
        seen.levels.green          = out_mon.green_lamp;
        seen.levels.yellow         = out_mon.yellow_lamp;
        seen.levels.red            = out_mon.red_lamp;
        seen.levels.fault          = out_mon.fault_lamp;
        seen.levels.severe         = out_mon.severe_fault_lamp;
        seen.levels.lv             = out_mon.low_volt_enable;
        seen.send_enable_frame     = out_mon.send_enable_frame;
        seen.pulse_controller_on   = out_mon.pulse_controller_on;
        seen.pulse_controller_off  = out_mon.pulse_controller_off;
        seen.mode_now              = out_mon.mode_now;
        if (predicted_results.size() == 0) begin
          $error("result with no item outstanding, mode_now %0d", seen.mode_now);
          fail_count_o++;
        end else begin
          want = predicted_results.pop_front();
          check_field("green_lamp", 3'(want.levels.green), 3'(seen.levels.green));
          check_field("yellow_lamp", 3'(want.levels.yellow), 3'(seen.levels.yellow));
          check_field("red_lamp", 3'(want.levels.red), 3'(seen.levels.red));
          check_field("fault_lamp", 3'(want.levels.fault), 3'(seen.levels.fault));
          check_field("severe_fault_lamp", 3'(want.levels.severe),
                      3'(seen.levels.severe));
          check_field("low_volt_enable", 3'(want.levels.lv), 3'(seen.levels.lv));
          check_field("send_enable_frame", 3'(want.send_enable_frame),
                      3'(seen.send_enable_frame));
          check_field("pulse_controller_on", 3'(want.pulse_controller_on),
                      3'(seen.pulse_controller_on));
          check_field("pulse_controller_off", 3'(want.pulse_controller_off),
                      3'(seen.pulse_controller_off));
          check_field("mode_now", want.mode_now, seen.mode_now);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        it.func          = in_mon.func;
        it.estop_on      = in_mon.estop_on;
        it.ignition_on   = in_mon.ignition_on;
        it.frame_id      = in_mon.frame_id;
        it.payload_byte0 = in_mon.payload_byte0;
        it.payload_byte1 = in_mon.payload_byte1;
        it.payload_byte6 = in_mon.payload_byte6;
        predicted_results.push_back(advance_sequencer(it));
      end
      pending_o = predicted_results.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dps_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned ItemW = $bits(item_t);
  localparam int unsigned LimW = $bits(limits_t);

  logic clk_i = 1'b0;
  logic rst_ni;

  dps_cfg_if cfg_ch ();
  dps_in_if  in_ch ();
  dps_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned n_steps;
  int unsigned n_frames;
  int unsigned n_settings;
  bit          quiet_run;     // no random idling on either side while set
  bit          ign_level;
  bit          estop_level;
  limits_t     cur_lim;

  drive_power_sequencer_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  power_seq_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_ch),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic item_t make_step(bit estop, bit ign);
    item_t it;
    it              = item_t'(ItemW'({$urandom(), $urandom()}));
    it.func         = 1'b0;
    it.estop_on     = estop;
    it.ignition_on  = ign;
    return it;
  endfunction

  function automatic item_t make_frame(logic [28:0] id, logic [15:0] word, logic [7:0] b6);
    item_t it;
    it.func          = 1'b1;
    it.estop_on      = 1'($urandom());
    it.ignition_on   = 1'($urandom());
    it.frame_id      = id;
    it.payload_byte0 = word[15:8];
    it.payload_byte1 = word[7:0];
    it.payload_byte6 = b6;
    return it;
  endfunction

  // half the time a value within two of the limit, else anything
  function automatic logic [15:0] near_limit(logic [15:0] lim);
    if ($urandom_range(0, 1) == 0) return 16'($urandom());
    return lim + 16'($urandom_range(0, 4)) - 16'd2;
  endfunction

  task automatic send_item(item_t it);
    int unsigned gap;
    gap = quiet_run ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.func          <= it.func;
    in_ch.estop_on      <= it.estop_on;
    in_ch.ignition_on   <= it.ignition_on;
    in_ch.frame_id      <= it.frame_id;
    in_ch.payload_byte0 <= it.payload_byte0;
    in_ch.payload_byte1 <= it.payload_byte1;
    in_ch.payload_byte6 <= it.payload_byte6;
    do @(posedge clk_i); while (!in_ch.ready);
    if (it.func) n_frames++;
    else n_steps++;
  endtask

  task automatic send_random_item();
    int unsigned kind;
    logic [15:0] word;
    logic [15:0] temp;
    logic [28:0] id;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      // levels persist for a while so states run their entry and exit
      if ($urandom_range(0, 3) == 0) ign_level = !ign_level;
      if ($urandom_range(0, 7) == 0) estop_level = !estop_level;
      send_item(make_step(estop_level, ign_level));
    end else if (kind == 6) begin
      word = near_limit(cur_lim.cell_volt);
      temp = near_limit({8'h00, cur_lim.cell_temp});
      send_item(make_frame(ID_CELLS, word, temp[7:0]));
    end else if (kind == 7) begin
      word = near_limit(cur_lim.board_temp);
      send_item(make_frame(ID_BOARD, word, 8'($urandom())));
    end else begin
      id = (kind == 8) ? 29'($urandom()) :
           (($urandom_range(0, 1) == 0 ? ID_CELLS : ID_BOARD) ^
            (29'd1 << $urandom_range(0, 28)));
      send_item(make_frame(id, 16'($urandom()), 8'($urandom())));
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic put_cfg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic apply_limits(limits_t lim, bit with_unused);
    cur_lim = lim;
    put_cfg(CFG_CELL_TEMP_LIMIT, {8'($urandom()), lim.cell_temp});
    put_cfg(CFG_CELL_VOLT_LIMIT, lim.cell_volt);
    put_cfg(CFG_BOARD_TEMP_LIMIT, lim.board_temp);
    if (with_unused) put_cfg(CFG_UNUSED, 16'($urandom()));
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // result side: random stalls, plus two long hold-offs that back up the pipe
  initial begin
    int unsigned taken;
    int unsigned stall;
    taken = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken == 40 || taken == 900) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk_i);
      end
      stall = quiet_run ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin
    limits_t lim;
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = 1'b0;
    in_ch.estop_on      = 1'b0;
    in_ch.ignition_on   = 1'b0;
    in_ch.frame_id      = '0;
    in_ch.payload_byte0 = '0;
    in_ch.payload_byte1 = '0;
    in_ch.payload_byte6 = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_CELL_TEMP_LIMIT;
    cfg_ch.data         = '0;
    cur_lim.cell_temp   = CELL_TEMP_LIMIT_RST;
    cur_lim.cell_volt   = CELL_VOLT_LIMIT_RST;
    cur_lim.board_temp  = BOARD_TEMP_LIMIT_RST;
    n_settings          = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the non-fault states: off, active, discharge by ignition and by estop, estop
    send_item(make_step(1'b0, 1'b0));
    send_item(make_step(1'b0, 1'b0));
    send_item(make_step(1'b0, 1'b1));
    send_item(make_step(1'b0, 1'b1));
    send_item(make_step(1'b1, 1'b1));
    send_item(make_step(1'b1, 1'b0));
    send_item(make_step(1'b1, 1'b0));
    send_item(make_step(1'b0, 1'b1));    // ignition alone keeps estop
    send_item(make_step(1'b0, 1'b0));
    send_item(make_step(1'b0, 1'b0));
    send_item(make_step(1'b0, 1'b1));
    send_item(make_step(1'b0, 1'b1));
    send_item(make_step(1'b0, 1'b0));
    send_item(make_step(1'b0, 1'b0));
    // telemetry extremes trip the warning, unknown ids change nothing
    send_item(make_frame(ID_CELLS, 16'h0000, 8'hFF));
    send_item(make_frame(ID_BOARD, 16'hFFFF, 8'h00));
    send_item(make_step(1'b0, 1'b0));
    send_item(make_frame(29'h1FFF_FFFF, 16'hFFFF, 8'hFF));
    send_item(make_frame(29'h0, 16'h0000, 8'h00));
    send_item(make_frame(ID_CELLS, 16'hFFFF, 8'h00));
    send_item(make_frame(ID_BOARD, 16'h0000, 8'hFF));
    send_item(make_step(1'b1, 1'b1));
    send_item(make_step(1'b1, 1'b1));
    send_item(make_step(1'b0, 1'b0));
    send_item(make_step(1'b0, 1'b0));

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        wait_drained();
        case (ph)
          1: lim = '0;
          2: lim = '1;
          5: begin
            lim.cell_temp  = CELL_TEMP_LIMIT_RST;
            lim.cell_volt  = CELL_VOLT_LIMIT_RST;
            lim.board_temp = BOARD_TEMP_LIMIT_RST;
          end
          default: lim = limits_t'(LimW'({$urandom(), $urandom()}));
        endcase
        apply_limits(lim, ph == 4);
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 50 == 0) quiet_run = ($urandom_range(0, 3) == 0);
        send_random_item();
      end
    end

    wait_drained();
    repeat (5) @(negedge clk_i);
    $display("summary: %0d steps and %0d telemetry frames under %0d limit settings",
             n_steps, n_frames, n_settings);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
